@@ hw/rtl/mi_pkg.sv @@
// Shared definitions for the modular inverse block: operand width, controller
// states and the command and status bundles between controller and datapath.
// No dependencies.
package mi_pkg;

	localparam int WIDTH = 63;
	localparam int CW    = WIDTH + 1;
	localparam int CNT_W = $clog2(WIDTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_SETUP,
		S_CHECK,
		S_DIVIDE,
		S_UPDATE,
		S_FINISH
	} mi_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic setup;
		logic start_div;
		logic update;
		logic finish;
	} mi_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic mod_zero;
		logic rem_nx_zero;
		logic out_free;
	} mi_sts_t;

endpackage

@@ hw/rtl/mi_req_if.sv @@
// Request channel: one beat carries a value and a modulus.
// Depends on mi_pkg.
interface mi_req_if import mi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] value;
	logic [WIDTH-1:0] modulus;

	modport source (output valid, output value, output modulus, input ready);
	modport sink (input valid, input value, input modulus, output ready);
endinterface

@@ hw/rtl/mi_rsp_if.sv @@
// Response channel: one beat carries the inverse and the exists flag.
// Depends on mi_pkg.
interface mi_rsp_if import mi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] inverse;
	logic             exists;

	modport source (output valid, output inverse, output exists, input ready);
	modport sink (input valid, input inverse, input exists, output ready);
endinterface

@@ hw/rtl/mi_ctrl.sv @@
// Controller of the modular inverse block: sequences the reduction, the Euclid
// rounds and the hand-off of the result. Depends on mi_pkg.
module mi_ctrl import mi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  mi_sts_t sts,
	output mi_cmd_t cmd
);

	mi_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_REDUCE;
			end
			S_REDUCE: begin
				if (sts.cnt_last) state_nx = S_SETUP;
			end
			S_SETUP: begin
				state_nx = sts.mod_zero ? S_FINISH : S_CHECK;
			end
			S_CHECK: begin
				state_nx = sts.rem_nx_zero ? S_FINISH : S_DIVIDE;
			end
			S_DIVIDE: begin
				if (sts.cnt_last) state_nx = S_UPDATE;
			end
			S_UPDATE: begin
				state_nx = S_CHECK;
			end
			S_FINISH: begin
				if (sts.out_free) state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_REDUCE: begin
				cmd.step = 1'b1;
			end
			S_SETUP: begin
				cmd.setup = !sts.mod_zero;
			end
			S_CHECK: begin
				cmd.start_div = !sts.rem_nx_zero;
			end
			S_DIVIDE: begin
				cmd.step = 1'b1;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
			end
			S_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/mi_dpath.sv @@
// Datapath of the modular inverse block: a bit-serial restoring divider that
// also builds quotient times coefficient, the Euclid registers and the result
// register. Depends on mi_pkg.
module mi_dpath import mi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] in_value,
	input  logic [WIDTH-1:0] in_modulus,
	input  mi_cmd_t          cmd,
	output mi_sts_t          sts,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_inverse,
	output logic             out_exists
);

	logic [WIDTH:0]   p_q, p_shift, trial;
	logic [WIDTH-1:0] dvd_q, dvs_q, rem_q, rem_nx_q, mod_q;
	logic [CW-1:0]    coef_q, coef_nx_q, acc_q, acc_step, coef_fix;
	logic [CNT_W-1:0] cnt_q;
	logic             qbit, valid_q, exists_c;
	logic [WIDTH-1:0] inv_q;
	logic             exists_q;

	assign p_shift  = {p_q[WIDTH-1:0], dvd_q[WIDTH-1]};
	assign qbit     = p_shift >= {1'b0, dvs_q};
	assign trial    = p_shift - {1'b0, dvs_q};
	assign acc_step = {acc_q[CW-2:0], 1'b0} + (qbit ? coef_nx_q : '0);
	assign coef_fix = coef_q[CW-1] ? coef_q + {1'b0, mod_q} : coef_q;
	assign exists_c = (mod_q != '0) && (rem_q == WIDTH'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mod_q <= in_modulus;
			dvd_q <= in_value;
			dvs_q <= in_modulus;
			p_q   <= '0;
			acc_q <= '0;
			cnt_q <= CNT_W'(WIDTH - 1);
		end else if (cmd.start_div) begin
			dvd_q <= rem_q;
			dvs_q <= rem_nx_q;
			p_q   <= '0;
			acc_q <= '0;
			cnt_q <= CNT_W'(WIDTH - 1);
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
			p_q   <= qbit ? trial : p_shift;
			acc_q <= acc_step;
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.setup) begin
			rem_q     <= mod_q;
			rem_nx_q  <= p_q[WIDTH-1:0];
			coef_q    <= '0;
			coef_nx_q <= CW'(1);
		end else if (cmd.update) begin
			rem_q     <= rem_nx_q;
			rem_nx_q  <= p_q[WIDTH-1:0];
			coef_q    <= coef_nx_q;
			coef_nx_q <= coef_q - acc_q;
		end
		if (cmd.finish) begin
			exists_q <= exists_c;
			inv_q    <= exists_c ? coef_fix[WIDTH-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.finish) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign sts.cnt_last    = cnt_q == '0;
	assign sts.mod_zero    = mod_q == '0;
	assign sts.rem_nx_zero = rem_nx_q == '0;
	assign sts.out_free    = !valid_q || out_ready;

	assign out_valid   = valid_q;
	assign out_inverse = inv_q;
	assign out_exists  = exists_q;

endmodule

@@ hw/rtl/modular_inverse.sv @@
// Top level of the modular inverse block: joins controller and datapath to
// the request and response channels. Depends on mi_pkg, mi_req_if, mi_rsp_if,
// mi_ctrl and mi_dpath.
//
// Each request beat returns one response beat with the inverse of value modulo
// modulus and an exists flag; a zero modulus, or a gcd other than one, gives
// inverse 0 with exists low. Items are handled one at a time by a bit-serial
// divider that retires one quotient bit per cycle. An item passes through the
// reduction of value modulo modulus, a setup, the Euclid rounds, each a
// division and an update, and then a closing check and the hand-off; a zero
// modulus skips the rounds and goes from setup straight to the hand-off.
// A finished result sits in an output register, so the next request is taken
// while it waits; a second result is held back until that register is free.
module modular_inverse import mi_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	mi_req_if.sink  req,
	mi_rsp_if.source rsp
);

	mi_cmd_t cmd;
	mi_sts_t sts;

	mi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mi_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_value    (req.value),
		.in_modulus  (req.modulus),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_inverse (rsp.inverse),
		.out_exists  (rsp.exists)
	);

endmodule
